@@ hdl/svptw_pkg.sv @@
package svptw_pkg;

  // Table store geometry; the depth is a power of two so the index wraps by truncation
  localparam int unsigned TABLE_WORDS = 4096;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_WORDS);

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // Configuration register indexes (paddr[2])
  localparam logic CFG_MMU_ENABLE = 1'b0;
  localparam logic CFG_ROOT_PAGE  = 1'b1;

  // Page table entry layout
  localparam int unsigned PTE_V = 0;

  // Table store access
  typedef struct packed {
    logic                we;
    logic [TABLE_AW-1:0] addr;
    logic [31:0]         wdata;
  } str_req_t;

endpackage

@@ hdl/svptw_store.sv @@
module svptw_store (
  input  logic                  clk,
  input  svptw_pkg::str_req_t   req,
  output logic [31:0]           rdata
);
  import svptw_pkg::*;

  logic [31:0] mem [TABLE_WORDS];
  logic [31:0] rdata_r;

  // Write one word, register the read word every cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/sv32_page_table_walker.sv @@
// Two-level Sv32-style page table walker over a word-addressed table store.
// Requests enter on start/busy: a request is taken at a rising edge with start
// high and busy low. in_opcode selects a table write (in_word_index,
// in_word_data) or a translation (in_virtual_address).
// A table write gives no result; busy stays low.
// With mmu_enable clear, a translation returns the virtual address as
// out_valid strobes in the cycle after the request, busy stays low.
// With mmu_enable set, the walk reads the level-1 entry through the store's
// single registered read port; a superpage leaf or a level-1 fault registers
// out_valid from S_L1 once the level-1 entry is read, a level-0 walk reads
// the level-0 entry and registers it from S_L0; busy is high in both states.
// The one read port is used once per level. A new request is taken in the
// cycle in which the previous result strobes.
// out_valid is a one-cycle strobe: the receiver cannot stall it.
// Configuration goes through an APB-style port: mmu_enable at byte 0,
// root_page at byte 4; pready is always high.
// Reset (rst_n low, synchronous) clears mmu_enable, root_page and the walk
// sequencer; the table store keeps no reset value and must be written first.
module sv32_page_table_walker (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [11:0] in_word_index,
  input  logic [31:0] in_word_data,
  input  logic [31:0] in_virtual_address,
  // result channel
  output logic        out_valid,
  output logic [33:0] out_physical_address,
  output logic        out_page_fault,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import svptw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_L1,
    S_L0
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] va_r, va_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [33:0] out_pa_r, out_pa_nxt;
  logic        out_fault_r, out_fault_nxt;
  logic        mmu_enable_r;
  logic [9:0]  root_page_r;

  str_req_t    store_req;
  logic [31:0] pte;
  logic        accept;
  logic        cfg_wr;
  logic [19:0] l1_idx;
  logic [31:0] l0_idx;
  logic [31:0] wr_idx;

  svptw_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (pte)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Form table word indexes; the store index wraps by truncation
  assign l1_idx = {root_page_r, in_virtual_address[31:22]};
  assign l0_idx = {pte[31:10], va_r[21:12]};
  assign wr_idx = 32'(in_word_index);

  // Drive the shared store port: table write or level-1 read on a request,
  // level-0 read from the level-1 entry while walking
  always_comb begin
    store_req.we    = 1'b0;
    store_req.addr  = l0_idx[TABLE_AW-1:0];
    store_req.wdata = in_word_data;
    if (accept) begin
      if (in_opcode == OP_WRITE) begin
        store_req.we   = 1'b1;
        store_req.addr = wr_idx[TABLE_AW-1:0];
      end else begin
        store_req.addr = l1_idx[TABLE_AW-1:0];
      end
    end
  end

  // Sequence the walk and form the result
  always_comb begin
    state_nxt     = state_r;
    va_nxt        = va_r;
    out_valid_nxt = 1'b0;
    out_pa_nxt    = out_pa_r;
    out_fault_nxt = out_fault_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == OP_XLATE)) begin
          va_nxt = in_virtual_address;
          if (mmu_enable_r) begin
            state_nxt = S_L1;
          end else begin
            out_valid_nxt = 1'b1;
            out_pa_nxt    = {2'b00, in_virtual_address};
            out_fault_nxt = 1'b0;
          end
        end
      end
      S_L1: begin
        if (!pte[PTE_V]) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_pa_nxt    = '0;
          out_fault_nxt = 1'b1;
        end else if (pte[3:1] != 3'b000) begin
          // superpage leaf
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_pa_nxt    = {pte[31:20], va_r[21:0]};
          out_fault_nxt = 1'b0;
        end else begin
          state_nxt = S_L0;
        end
      end
      S_L0: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (!pte[PTE_V] || (pte[3:1] == 3'b000)) begin
          out_pa_nxt    = '0;
          out_fault_nxt = 1'b1;
        end else begin
          out_pa_nxt    = {pte[31:10], va_r[11:0]};
          out_fault_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    va_r        <= va_nxt;
    out_pa_r    <= out_pa_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_page_fault       = out_fault_r;

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmu_enable_r <= 1'b0;
      root_page_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_MMU_ENABLE: mmu_enable_r <= pwdata[0];
        CFG_ROOT_PAGE:  root_page_r  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_ROOT_PAGE) ? {22'd0, root_page_r}
                                              : {31'd0, mmu_enable_r};

  // Pass-through translation strobes a result in the next cycle
  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_XLATE) && !mmu_enable_r) |=> out_valid)
    else $error("pass-through result missing");

  // A table write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_WRITE)) |=> !out_valid)
    else $error("table write produced a result");

  // A level-0 read always ends the walk with a result
  a_l0_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_L0) |=> (out_valid && (state_r == S_IDLE)))
    else $error("level-0 step did not finish the walk");

  // A fault reports a zero address
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_fault) |-> (out_physical_address == '0))
    else $error("fault with nonzero address");

endmodule
